### rtl/cubic_bezier_point_eval_top_defines.svh
// Assertion macros shared by the cubic Bezier evaluator RTL.
`ifndef CUBIC_BEZIER_POINT_EVAL_TOP_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVAL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define BEZ_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent in this cycle implies consequent in the next.
`define BEZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BEZ_ASSERT(lbl, expr, msg)
`define BEZ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/bez_pkg.sv
// Package: constants, types and the Bernstein weight function of the Bezier evaluator.
`timescale 1ns / 1ps
package bez_pkg;

    localparam int STEPS_DEF     = 100;
    localparam int FRAC_BITS_DEF = 32;

    localparam int COORD_W   = 16;  // control point coordinate / result width
    localparam int STEP_W    = 7;   // step_index width
    localparam int N_CTRL    = 4;   // control points
    localparam int N_REGS    = 2 * N_CTRL;
    localparam int CFG_IDX_W = 3;
    localparam int TERM_W    = COORD_W + 2;  // signed term, |term| <= 2^15
    localparam int SUM_W     = TERM_W + 2;   // sum of four terms

    typedef struct packed {
        logic prod;  // load partial products
        logic term;  // load signed term
    } term_en_t;

    // floor(C(3,idx) * k^idx * (steps-k)^(3-idx) * 2^frac_bits / steps^3),
    // by restoring division; evaluated at elaboration only.
    function automatic logic [63:0] bez_weight(input int steps, input int frac_bits,
                                               input int k, input int idx);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        int          j;
        int          b;
        num = (idx == 1 || idx == 2) ? 64'd3 : 64'd1;
        for (j = 0; j < 3; j++)
        begin
            num = num * ((j < idx) ? 64'(k) : 64'(steps - k));
        end
        den = 64'(steps) * 64'(steps) * 64'(steps);
        if (num >= den)
        begin
            q = 64'd1;
            r = num - den;
        end
        else
        begin
            q = 64'd0;
            r = num;
        end
        for (b = 0; b < frac_bits; b++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

endpackage

### rtl/bez_term.sv
// One weight-times-coordinate term: split product, then truncation toward zero.
`timescale 1ns / 1ps
module bez_term #(
    parameter int FRAC_BITS = bez_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  bez_pkg::term_en_t                  en,
    input  logic [FRAC_BITS:0]                 weight,
    input  logic signed [bez_pkg::COORD_W-1:0] coord,
    output logic signed [bez_pkg::TERM_W-1:0]  term
);
    import bez_pkg::*;

    localparam int WW    = FRAC_BITS + 1;
    localparam int SPLIT = (WW + 1) / 2;
    localparam int HI_W  = WW - SPLIT;

    logic              neg;
    logic [COORD_W-1:0] mag;   // 0x8000 reads as 32768

    logic [SPLIT+COORD_W-1:0] lo_reg;
    logic [SPLIT+COORD_W-1:0] lo_next;
    logic [HI_W+COORD_W-1:0]  hi_reg;
    logic [HI_W+COORD_W-1:0]  hi_next;
    logic [WW+COORD_W-1:0]    full;
    logic [COORD_W:0]         tmag;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [TERM_W-1:0] term_next;

    assign neg = coord[COORD_W-1];
    assign mag = neg ? COORD_W'(-coord) : COORD_W'(coord);

    // two narrow products instead of one wide one
    assign lo_next = (SPLIT+COORD_W)'(weight[SPLIT-1:0]) * (SPLIT+COORD_W)'(mag);
    assign hi_next = (HI_W+COORD_W)'(weight[WW-1:SPLIT]) * (HI_W+COORD_W)'(mag);

    assign full = {hi_reg, {SPLIT{1'b0}}} + (WW+COORD_W)'(lo_reg);
    assign tmag = full[WW+COORD_W-1:FRAC_BITS];
    assign term_next = neg ? -TERM_W'(tmag) : TERM_W'(tmag);

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (en.term)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

### rtl/cubic_bezier_point_eval_top.sv
// Cubic Bezier point evaluator top level: config registers, weight table, pipeline.
`timescale 1ns / 1ps
// An accepted input beat moves through the five register stages; its result beat shows on m_tvalid.
// Throughput: one beat per cycle while the output is not stalled; five register stages, each with its own valid bit.
// Stages: clamp step, weight table read, split products, truncated terms, sum and saturate.
// A stalled output holds the full stages behind it; the first empty stage still takes a beat.
// Reset (rst_n, async, active low) empties the pipeline and clears all control points to 0.
module cubic_bezier_point_eval_top #(
    parameter int STEPS     = bez_pkg::STEPS_DEF,
    parameter int FRAC_BITS = bez_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [bez_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bez_pkg::COORD_W-1:0]        cfg_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [6:0] step_index, [7] zero
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata    // [15:0] point_x, [31:16] point_y
);
    import bez_pkg::*;

    `include "cubic_bezier_point_eval_top_defines.svh"

    localparam int WW   = FRAC_BITS + 1;      // weight 1.0 = 2^FRAC_BITS needs one more bit
    localparam int NK   = 2 ** STEP_W;        // table spans every step_index code
    localparam int KMAX = (STEPS > NK - 1) ? NK - 1 : STEPS;
    localparam logic [STEP_W-1:0] KMAX_K = STEP_W'(KMAX);
    localparam logic [WW+1:0]     W_ONE  = (WW+2)'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Control point registers: even index x, odd index y
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] ctrl_reg [0:N_REGS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_REGS; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            ctrl_reg[cfg_index] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Bernstein weight table, built at elaboration. Codes above the
    // clamp point repeat its row; they are never looked up.
    // ------------------------------------------------------------------
    logic [WW-1:0] w_rom [0:NK-1][0:N_CTRL-1];

    for (genvar g = 0; g < NK; g++)
    begin : g_row
        localparam int KE = (g > KMAX) ? KMAX : g;
        for (genvar p = 0; p < N_CTRL; p++)
        begin : g_col
            assign w_rom[g][p] = WW'(bez_weight(STEPS, FRAC_BITS, KE, p));
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp step_index to the curve end
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] k_in;
    logic [STEP_W-1:0] k_reg;
    logic [STEP_W-1:0] k_next;

    assign k_in   = s_tdata[STEP_W-1:0];
    assign k_next = (k_in > KMAX_K) ? KMAX_K : k_in;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            k_reg <= k_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weight lookup
    // ------------------------------------------------------------------
    logic [WW-1:0] w_reg [0:N_CTRL-1];

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            for (int p = 0; p < N_CTRL; p++)
            begin
                w_reg[p] <= w_rom[k_reg][p];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: eight terms, one unit per coordinate
    // ------------------------------------------------------------------
    term_en_t                 term_en;
    logic signed [TERM_W-1:0] term [0:N_REGS-1];

    assign term_en.prod = rdy3;
    assign term_en.term = rdy4;

    for (genvar r = 0; r < N_REGS; r++)
    begin : g_term
        bez_term #(
            .FRAC_BITS (FRAC_BITS)
        ) u_term (
            .clk    (clk),
            .en     (term_en),
            .weight (w_reg[r / 2]),
            .coord  (ctrl_reg[r]),
            .term   (term[r])
        );
    end

    // ------------------------------------------------------------------
    // Stage 5: per-axis sum, saturate to 16-bit signed
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] px_next;
    logic signed [COORD_W-1:0] py_reg;
    logic signed [COORD_W-1:0] py_next;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    assign sum_x = SUM_W'(term[0]) + SUM_W'(term[2]) + SUM_W'(term[4]) + SUM_W'(term[6]);
    assign sum_y = SUM_W'(term[1]) + SUM_W'(term[3]) + SUM_W'(term[5]) + SUM_W'(term[7]);

    always_comb
    begin
        priority if (sum_x > SAT_HI) px_next = 16'sh7FFF;
        else if (sum_x < SAT_LO)     px_next = -16'sh8000;
        else                         px_next = COORD_W'(sum_x);
        priority if (sum_y > SAT_HI) py_next = 16'sh7FFF;
        else if (sum_y < SAT_LO)     py_next = -16'sh8000;
        else                         py_next = COORD_W'(sum_y);
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    assign m_tdata = {py_reg, px_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic [WW+1:0] w_sum;
    assign w_sum = (WW+2)'(w_reg[0]) + (WW+2)'(w_reg[1]) + (WW+2)'(w_reg[2])
                 + (WW+2)'(w_reg[3]);

    `BEZ_ASSERT(a_k_clamped, !v1_reg || (k_reg <= KMAX_K), "step not clamped")
    `BEZ_ASSERT(a_w_sum, !v2_reg || (w_sum <= W_ONE), "weights sum above one")
    `BEZ_ASSERT_NEXT(a_in_to_s1, s_tvalid && s_tready, v1_reg, "accepted beat lost")
    `BEZ_ASSERT_NEXT(a_s4_to_s5, v4_reg && rdy5, v5_reg, "term beat lost")
    `BEZ_ASSERT(a_bubble_ready, v1_reg || s_tready, "empty first stage not ready")

endmodule
